// File: src/wtp_pkg.sv
// shared types, constants and register codes for the wrench to thruster pulse block
package wtp_pkg;

   localparam int NumAxes  = 6;
   localparam int NumTorq  = 3;
   localparam int ValW     = 20;
   localparam int DivW     = 20;
   localparam int MulW     = 16;
   localparam int NumW     = DivW + MulW;
   localparam int DivSteps = 16;
   localparam int XW       = 17;
   localparam int QueDepth = 4;
   localparam int QueCntW  = $clog2(QueDepth + 1);
   localparam int BackLen  = DivSteps + 4;

   localparam logic [15:0] NeutralPulse = 16'd1500;

   localparam logic [14:0]        UpperReset = 15'd5632;
   localparam logic signed [15:0] LowerReset = -16'sd5632;
   localparam logic signed [15:0] ArmReset   = 16'sd4096;
   localparam logic [47:0]        CurveReset = 48'd1500;

   typedef enum logic [2:0] {
      REG_UPPER   = 3'd0,
      REG_LOWER   = 3'd1,
      REG_ROLL    = 3'd2,
      REG_PITCH   = 3'd3,
      REG_YAW     = 3'd4,
      REG_FORWARD = 3'd5,
      REG_REVERSE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [14:0]                upper;
      logic signed [15:0]         lower;
      logic [NumTorq-1:0][15:0]   arm;
      logic [47:0]                fwd;
      logic [47:0]                rev;
   } cfg_type;

   typedef struct packed {
      logic [NumAxes-1:0][ValW-1:0] v;
      logic [DivW-1:0]              a;
      logic [MulW-1:0]              b;
      logic                         scale;
   } item_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               full;
      logic [QueCntW-1:0] count;
   } que_stat_type;

endpackage

// File: src/wtp_ifs.sv
// request, response and register write channel interfaces
interface wtp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] surge_force;
   logic signed [15:0] sway_force;
   logic signed [15:0] heave_force;
   logic signed [15:0] roll_torque;
   logic signed [15:0] pitch_torque;
   logic signed [15:0] yaw_torque;
   modport source (output valid, surge_force, sway_force, heave_force, roll_torque,
                   pitch_torque, yaw_torque, input ready);
   modport sink (input valid, surge_force, sway_force, heave_force, roll_torque,
                 pitch_torque, yaw_torque, output ready);
endinterface

interface wtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pitch_pulse;
   logic [15:0] roll_pulse;
   logic [15:0] heave_pulse;
   logic [15:0] yaw_pulse;
   logic [15:0] surge_pulse;
   logic [15:0] sway_pulse;
   modport source (output valid, pitch_pulse, roll_pulse, heave_pulse, yaw_pulse,
                   surge_pulse, sway_pulse, input ready);
   modport sink (input valid, pitch_pulse, roll_pulse, heave_pulse, yaw_pulse,
                 surge_pulse, sway_pulse, output ready);
endinterface

interface wtp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/wrench_to_thruster_pwm.sv
// top level: wrench request to six thruster pulse widths
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   six signed q8.8 axes
//  rsp_ch   out  valid/ready   six 16 bit pulse widths
//  csr_ch   in   valid/ready   3 bit register index, 48 bit data
// one request per cycle sustained while responses are taken; the path holds
// 4 front stages, 1 queue entry, 1 scale multiply, 16 divider stages, 3 curve and output
// the divider pipeline sets the length; a 4 entry queue splits front and back
// reset clears valid state and loads default registers; csr always ready
// a stalled response holds the back pipeline, front runs on until the queue fills
module wrench_to_thruster_pwm (
   input  logic      clock,
   input  logic      reset,
   wtp_req_if.sink   req_ch,
   wtp_rsp_if.source rsp_ch,
   wtp_csr_if.sink   csr_ch
);

   wtp_pkg::cfg_type                     cfg_ff;
   logic [wtp_pkg::NumAxes-1:0][15:0]    axes;
   logic [wtp_pkg::NumAxes-1:0][15:0]    pulse;
   wtp_pkg::item_type                    f_item, b_item;
   wtp_pkg::que_stat_type                q_stat;
   logic                                 f_valid, f_ready, b_valid, b_take;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper <= wtp_pkg::UpperReset;
         cfg_ff.lower <= wtp_pkg::LowerReset;
         cfg_ff.arm   <= {3{wtp_pkg::ArmReset}};
         cfg_ff.fwd   <= wtp_pkg::CurveReset;
         cfg_ff.rev   <= wtp_pkg::CurveReset;
      end else if (csr_ch.valid) begin
         unique case (wtp_pkg::reg_index_type'(csr_ch.index))
            wtp_pkg::REG_UPPER:   cfg_ff.upper  <= csr_ch.data[14:0];
            wtp_pkg::REG_LOWER:   cfg_ff.lower  <= csr_ch.data[15:0];
            wtp_pkg::REG_ROLL:    cfg_ff.arm[0] <= csr_ch.data[15:0];
            wtp_pkg::REG_PITCH:   cfg_ff.arm[1] <= csr_ch.data[15:0];
            wtp_pkg::REG_YAW:     cfg_ff.arm[2] <= csr_ch.data[15:0];
            wtp_pkg::REG_FORWARD: cfg_ff.fwd    <= csr_ch.data;
            wtp_pkg::REG_REVERSE: cfg_ff.rev    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign axes[0] = req_ch.surge_force;
   assign axes[1] = req_ch.sway_force;
   assign axes[2] = req_ch.heave_force;
   assign axes[3] = req_ch.roll_torque;
   assign axes[4] = req_ch.pitch_torque;
   assign axes[5] = req_ch.yaw_torque;

   wtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .axes      (axes),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .item      (f_item)
   );

   wtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop        (b_take),
      .pop_item   (b_item),
      .stat       (q_stat)
   );

   wtp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (b_valid),
      .in_take   (b_take),
      .item      (b_item),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .pulse     (pulse)
   );

   assign rsp_ch.pitch_pulse = pulse[4];
   assign rsp_ch.roll_pulse  = pulse[3];
   assign rsp_ch.heave_pulse = pulse[2];
   assign rsp_ch.yaw_pulse   = pulse[5];
   assign rsp_ch.surge_pulse = pulse[0];
   assign rsp_ch.sway_pulse  = pulse[1];

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= wtp_pkg::QueCntW'(wtp_pkg::QueDepth))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.push |-> !q_stat.full)
      else $error("queue push while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_stat.pop |-> (q_stat.count != '0))
      else $error("queue pop while empty");

endmodule

// File: src/wtp_front.sv
// front pipeline: torque scaling, extremes and choice of common scale factor
module wtp_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wtp_pkg::cfg_type                        cfg,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [wtp_pkg::NumAxes-1:0][15:0]       axes,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output wtp_pkg::item_type                       item
);

   logic [3:0]         vld_ff;
   logic               en;
   logic signed [15:0] force_ff [3];
   logic signed [31:0] prod_ff [3];
   logic signed [wtp_pkg::ValW-1:0] v2_ff [6];
   logic signed [wtp_pkg::ValW-1:0] v3_ff [6];
   logic signed [wtp_pkg::ValW-1:0] v4_ff [6];
   logic signed [wtp_pkg::ValW-1:0] hi3_ff, lo3_ff, hi4_ff, lo4_ff;
   logic signed [wtp_pkg::ValW-1:0] hi_in, lo_in;
   logic signed [31:0] rnd [3];
   logic               over4_ff, under4_ff;
   logic signed [37:0] pa4_ff, pb4_ff;
   logic [14:0]        up;
   logic [15:0]        neglw;
   logic signed [16:0] lw;
   logic               take_hi;
   logic signed [wtp_pkg::ValW:0] neglo;

   assign en        = !vld_ff[3] || out_ready;
   assign in_ready  = en;
   assign out_valid = vld_ff[3];

   assign up    = (cfg.upper == 15'd0) ? 15'd1 : cfg.upper;
   assign lw    = cfg.lower[15] ? 17'(cfg.lower) : -17'sd1;
   assign neglw = cfg.lower[15] ? 16'(-cfg.lower) : 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i] = prod_ff[i] + 32'sd2048;
      end
      hi_in = v2_ff[0];
      lo_in = v2_ff[0];
      for (int i = 1; i < 6; i++) begin
         if (v2_ff[i] > hi_in) hi_in = v2_ff[i];
         if (v2_ff[i] < lo_in) lo_in = v2_ff[i];
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            force_ff[i] <= $signed(axes[i]);
            prod_ff[i]  <= $signed(axes[3+i]) * $signed(cfg.arm[i]);
         end
         for (int i = 0; i < 3; i++) begin
            v2_ff[i]   <= wtp_pkg::ValW'(force_ff[i]);
            v2_ff[3+i] <= rnd[i][31:12];
         end
         for (int i = 0; i < 6; i++) begin
            v3_ff[i] <= v2_ff[i];
            v4_ff[i] <= v3_ff[i];
         end
         hi3_ff    <= hi_in;
         lo3_ff    <= lo_in;
         hi4_ff    <= hi3_ff;
         lo4_ff    <= lo3_ff;
         over4_ff  <= hi3_ff > $signed({5'b0, up});
         under4_ff <= lo3_ff < lw;
         pa4_ff    <= 38'(hi3_ff) * $signed({1'b0, neglw});
         pb4_ff    <= (-21'(lo3_ff)) * $signed({2'b0, up});
      end
   end

   assign neglo   = -21'(lo4_ff);
   assign take_hi = over4_ff && (!under4_ff || (pa4_ff >= pb4_ff));

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         item.v[i] = v4_ff[i];
      end
      item.a     = take_hi ? hi4_ff : neglo[wtp_pkg::DivW-1:0];
      item.b     = take_hi ? {1'b0, up} : neglw;
      item.scale = over4_ff || under4_ff;
   end

endmodule

// File: src/wtp_queue.sv
// short queue between front and back pipelines
module wtp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  wtp_pkg::item_type     push_item,
   output logic                  pop_valid,
   input  logic                  pop,
   output wtp_pkg::item_type     pop_item,
   output wtp_pkg::que_stat_type stat
);

   wtp_pkg::item_type                 ent_ff [wtp_pkg::QueDepth];
   logic [wtp_pkg::QueCntW-1:0]       cnt_ff, cnt_in;
   logic [wtp_pkg::QueCntW-1:0]       wpos;
   logic                              push;
   logic                              full;

   assign full       = (cnt_ff == wtp_pkg::QueCntW'(wtp_pkg::QueDepth));
   assign push_ready = !full;
   assign push       = push_valid && !full;
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = ent_ff[0];
   assign wpos       = cnt_ff - {{(wtp_pkg::QueCntW-1){1'b0}}, pop};
   assign cnt_in     = wpos + {{(wtp_pkg::QueCntW-1){1'b0}}, push};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // head stays at entry zero, entries shift down on pop
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < wtp_pkg::QueDepth - 1; i++) begin
            ent_ff[i] <= ent_ff[i+1];
         end
      end
      if (push) begin
         ent_ff[wpos[wtp_pkg::QueCntW-2:0]] <= push_item;
      end
   end

   assign stat.push  = push;
   assign stat.pop   = pop;
   assign stat.full  = full;
   assign stat.count = cnt_ff;

endmodule

// File: src/wtp_back.sv
// back pipeline: common scaling divide and quadratic pulse curves
module wtp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  wtp_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   output logic                                in_take,
   input  wtp_pkg::item_type                   item,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [wtp_pkg::NumAxes-1:0][15:0]   pulse
);

   localparam int Last = wtp_pkg::DivSteps;

   logic [wtp_pkg::BackLen-1:0]      vld_ff;
   logic                             en;
   logic [wtp_pkg::NumW-1:0]         rem_ff [0:Last][6];
   logic [wtp_pkg::NumW-1:0]         rem_in [0:Last][6];
   logic [15:0]                      q_ff [0:Last][6];
   logic [15:0]                      q_in [0:Last][6];
   logic [wtp_pkg::DivW-1:0]         a_ff [0:Last];
   logic                             scale_ff [0:Last];
   logic                             neg_ff [0:Last][6];
   logic signed [wtp_pkg::ValW-1:0]  v_ff [0:Last][6];
   logic [wtp_pkg::ValW-1:0]         mag [6];
   logic signed [wtp_pkg::XW-1:0]    x [6];
   logic [47:0]                      crv [6];
   logic signed [33:0]               xx_ff [6];
   logic signed [32:0]               lx1_ff [6];
   logic signed [32:0]               lx2_ff [6];
   logic signed [15:0]               qd1_ff [6];
   logic signed [15:0]               c1_ff [6];
   logic signed [15:0]               c2_ff [6];
   logic                             z1_ff [6];
   logic                             z2_ff [6];
   logic signed [47:0]               qxx_ff [6];
   logic signed [49:0]               sum [6];
   logic signed [25:0]               p [6];
   logic [15:0]                      pulse_ff [6];

   assign en        = !vld_ff[wtp_pkg::BackLen-1] || out_ready;
   assign in_take   = en && in_valid;
   assign out_valid = vld_ff[wtp_pkg::BackLen-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[wtp_pkg::BackLen-2:0], in_valid};
      end
   end

   always_comb begin
      logic [wtp_pkg::NumW-1:0] sh;
      for (int i = 0; i < 6; i++) begin
         mag[i]       = item.v[i][wtp_pkg::ValW-1] ? -item.v[i] : item.v[i];
         rem_in[0][i] = '0;
         q_in[0][i]   = '0;
      end
      // one quotient bit per stage, msb first
      for (int s = 0; s < Last; s++) begin
         sh = wtp_pkg::NumW'(a_ff[s]) << (Last - 1 - s);
         for (int i = 0; i < 6; i++) begin
            if (rem_ff[s][i] >= sh) begin
               rem_in[s+1][i] = rem_ff[s][i] - sh;
               q_in[s+1][i]   = q_ff[s][i] | (16'd1 << (Last - 1 - s));
            end else begin
               rem_in[s+1][i] = rem_ff[s][i];
               q_in[s+1][i]   = q_ff[s][i];
            end
         end
      end
      for (int i = 0; i < 6; i++) begin
         if (!scale_ff[Last]) begin
            x[i] = v_ff[Last][i][wtp_pkg::XW-1:0];
         end else if (neg_ff[Last][i]) begin
            x[i] = -$signed({1'b0, q_ff[Last][i]});
         end else begin
            x[i] = $signed({1'b0, q_ff[Last][i]});
         end
         crv[i] = x[i][wtp_pkg::XW-1] ? cfg.rev : cfg.fwd;
         sum[i] = 50'(qxx_ff[i]) + (50'(lx2_ff[i]) <<< 8) + (50'(c2_ff[i]) <<< 24)
                  + (50'sd1 <<< 23);
         p[i]   = sum[i][49:24];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]     <= item.a;
         scale_ff[0] <= item.scale;
         for (int i = 0; i < 6; i++) begin
            rem_ff[0][i] <= wtp_pkg::NumW'(mag[i]) * wtp_pkg::NumW'(item.b);
            q_ff[0][i]   <= '0;
            neg_ff[0][i] <= item.v[i][wtp_pkg::ValW-1];
            v_ff[0][i]   <= $signed(item.v[i]);
         end
         for (int s = 1; s <= Last; s++) begin
            a_ff[s]     <= a_ff[s-1];
            scale_ff[s] <= scale_ff[s-1];
            for (int i = 0; i < 6; i++) begin
               rem_ff[s][i] <= rem_in[s][i];
               q_ff[s][i]   <= q_in[s][i];
               neg_ff[s][i] <= neg_ff[s-1][i];
               v_ff[s][i]   <= v_ff[s-1][i];
            end
         end
         for (int i = 0; i < 6; i++) begin
            xx_ff[i]  <= x[i] * x[i];
            lx1_ff[i] <= $signed(crv[i][31:16]) * x[i];
            qd1_ff[i] <= $signed(crv[i][47:32]);
            c1_ff[i]  <= $signed(crv[i][15:0]);
            z1_ff[i]  <= (x[i] == '0);
            qxx_ff[i] <= qd1_ff[i] * $signed({1'b0, xx_ff[i][30:0]});
            lx2_ff[i] <= lx1_ff[i];
            c2_ff[i]  <= c1_ff[i];
            z2_ff[i]  <= z1_ff[i];
            if (z2_ff[i]) begin
               pulse_ff[i] <= wtp_pkg::NeutralPulse;
            end else if (p[i] < 0) begin
               pulse_ff[i] <= 16'd0;
            end else if (p[i] > 26'sd65535) begin
               pulse_ff[i] <= 16'hffff;
            end else begin
               pulse_ff[i] <= p[i][15:0];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pulse[i] = pulse_ff[i];
      end
   end

endmodule
